@@ rtl/core/dtq_pkg.sv @@
// Package for the delta-list timer queue: payload words, status and op codes,
// and the command word that the controller broadcasts to the cell row.
// No dependencies.
`default_nettype none

package dtq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
  } dtq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  front_task;
    logic [15:0] front_delta;
    logic [4:0]  entry_count;
  } dtq_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] task_id;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/dtq_cell.sv @@
// One slot of the timer queue: holds a task id and its delta, and takes a new
// entry, its left neighbor or its right neighbor on command.
// Depends on dtq_pkg.
`default_nettype none

module dtq_cell
  import dtq_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 4,
  parameter int DELAY_BITS = 16
) (
  input  wire                   clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire [IDX_W-1:0]       pos_i,
  input  wire [DELAY_BITS-1:0]  new_delta_i,
  input  wire [DELAY_BITS-1:0]  sub_i,
  input  wire [7:0]             left_task_i,
  input  wire [DELAY_BITS-1:0]  left_delta_i,
  input  wire [7:0]             right_task_i,
  input  wire [DELAY_BITS-1:0]  right_delta_i,
  output logic [7:0]            task_o,
  output logic [DELAY_BITS-1:0] delta_o
);

  localparam logic [IDX_W:0] MyIdx = (IDX_W+1)'(INDEX);

  logic [7:0]            task_q, task_d;
  logic [DELAY_BITS-1:0] delta_q, delta_d;
  logic [IDX_W:0]        pos_ext;
  logic                  at_pos, after_pos, past_pos;

  assign pos_ext   = {1'b0, pos_i};
  assign at_pos    = (MyIdx == pos_ext);
  assign after_pos = (MyIdx == pos_ext + 1'b1);
  assign past_pos  = (MyIdx > pos_ext);

  always_comb begin
    task_d  = task_q;
    delta_d = delta_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (at_pos) begin
          task_d  = cmd_i.task_id;
          delta_d = new_delta_i;
        end else if (after_pos) begin
          // the displaced entry now counts from the new one
          task_d  = left_task_i;
          delta_d = left_delta_i - sub_i;
        end else if (past_pos) begin
          task_d  = left_task_i;
          delta_d = left_delta_i;
        end
      end
      CELL_REMOVE: begin
        task_d  = right_task_i;
        delta_d = right_delta_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    task_q  <= task_d;
    delta_q <= delta_d;
  end

  assign task_o  = task_q;
  assign delta_o = delta_q;

endmodule

`default_nettype wire

@@ rtl/core/delta_timer_queue_top.sv @@
// Top level of the delta-list timer queue: controller, walk registers and the
// row of dtq_cell slots. Depends on dtq_pkg and dtq_cell.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_word_i carries one command word:
//   insert task_id with absolute delay_ticks, or remove the front entry.
//   Output channel out_valid_o / out_stall_i / out_word_o returns one word per
//   command: status, front task, front delta and entry count after the command.
//   A word is taken at a clock edge with valid high and stall low.
//   Remove, rejected insert, insert into an empty queue and insert at the tail
//   pass from acceptance through the execute step and the report step to the
//   result word. An insert into the middle walks the slots from the front, one
//   slot per cycle, to the slot it lands in, and then goes to the report step.
//   One command is in flight at a time; in_stall_o stays high until its result
//   word has been loaded into the output register, and the next command can be
//   taken while that word still waits on the receiver.
//   A stall on the output holds the result word and, once another command has
//   finished, holds that command in its report step until the word is taken.
//   Reset empties the queue and clears the running total; slot contents are
//   not cleared and are never read before they are written.
`default_nettype none

module delta_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DELAY_BITS  = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire dtq_in_t in_word_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output dtq_out_t     out_word_o
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FullCount = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DELAY_BITS-1:0] total_q, total_d;
  logic [DELAY_BITS-1:0] rest_q, rest_d;
  logic [IDX_W-1:0]      walk_q, walk_d;
  logic [1:0]            status_q, status_d;
  logic [7:0]            task_q;
  logic                  op_q;
  logic                  out_valid_q;
  dtq_out_t              out_word_q;

  cell_cmd_t             cmd;
  logic [IDX_W-1:0]      pos;
  logic [DELAY_BITS-1:0] new_delta, sub;
  logic [DELAY_BITS-1:0] walk_delta;

  logic [7:0]            cell_task  [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0] cell_delta [QUEUE_DEPTH];

  logic in_take, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_delta = cell_delta[walk_q];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    rest_d      = rest_q;
    walk_d      = walk_q;
    status_d    = status_q;
    cmd.op      = CELL_HOLD;
    cmd.task_id = task_q;
    pos         = '0;
    new_delta   = rest_q;
    sub         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          rest_d  = DELAY_BITS'(in_word_i.delay_ticks);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = STATUS_DONE;
        state_d  = S_REPORT;
        if (op_q == OP_REMOVE) begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            cmd.op  = CELL_REMOVE;
            total_d = total_q - cell_delta[0];
            count_d = count_q - 1'b1;
          end
        end else if (count_q == FullCount) begin
          status_d = STATUS_FULL;
        end else if (count_q == '0) begin
          cmd.op    = CELL_INSERT;
          total_d   = rest_q;
          count_d   = count_q + 1'b1;
        end else if (rest_q >= total_q) begin
          // append at the tail, delta counts from the last entry
          cmd.op    = CELL_INSERT;
          pos       = IDX_W'(count_q);
          new_delta = rest_q - total_q;
          total_d   = rest_q;
          count_d   = count_q + 1'b1;
        end else begin
          walk_d  = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (CNT_W'(walk_q) == count_q) begin
          cmd.op  = CELL_INSERT;
          pos     = walk_q;
          total_d = total_q + rest_q;
          count_d = count_q + 1'b1;
          state_d = S_REPORT;
        end else if (walk_delta >= rest_q) begin
          // split the slot: new entry takes rest, old one keeps the remainder
          cmd.op  = CELL_INSERT;
          pos     = walk_q;
          sub     = rest_q;
          count_d = count_q + 1'b1;
          state_d = S_REPORT;
        end else begin
          rest_d = rest_q - walk_delta;
          walk_d = walk_q + 1'b1;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if ((state_q == S_REPORT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    walk_q   <= walk_d;
    status_q <= status_d;
    if (in_take) begin
      task_q <= in_word_i.task_id;
      op_q   <= in_word_i.op;
    end
    if ((state_q == S_REPORT) && out_free) begin
      out_word_q.status      <= status_q;
      out_word_q.entry_count <= 5'(count_q);
      if (count_q == '0) begin
        out_word_q.front_task  <= '0;
        out_word_q.front_delta <= '0;
      end else begin
        out_word_q.front_task  <= cell_task[0];
        out_word_q.front_delta <= 16'(cell_delta[0]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic [7:0]            left_task, right_task;
    logic [DELAY_BITS-1:0] left_delta, right_delta;

    if (gi == 0) begin : g_head
      assign left_task  = '0;
      assign left_delta = '0;
    end else begin : g_mid
      assign left_task  = cell_task[gi-1];
      assign left_delta = cell_delta[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign right_task  = '0;
      assign right_delta = '0;
    end else begin : g_body
      assign right_task  = cell_task[gi+1];
      assign right_delta = cell_delta[gi+1];
    end

    dtq_cell #(
      .INDEX      (gi),
      .IDX_W      (IDX_W),
      .DELAY_BITS (DELAY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .pos_i         (pos),
      .new_delta_i   (new_delta),
      .sub_i         (sub),
      .left_task_i   (left_task),
      .left_delta_i  (left_delta),
      .right_task_i  (right_task),
      .right_delta_i (right_delta),
      .task_o        (cell_task[gi]),
      .delta_o       (cell_delta[gi])
    );
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count beyond queue depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
    (count_q == $past(count_q) - 1'b1))
    else $error("entry count moved by more than one");

  a_walk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((CNT_W'(walk_q) <= count_q) && (count_q != FullCount)))
    else $error("walk pointer past the last entry");

  a_report_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_REPORT) && out_free) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("report step did not load the output word");

  a_cells_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) || (state_q == S_REPORT)) |-> (cmd.op == CELL_HOLD))
    else $error("cell row changed outside execution");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for delta_timer_queue_top: drives insert and remove words and
// checks each report word against a delta-list model kept in a small class.
// Depends on dtq_pkg and the RTL under rtl/core.

module tb;
  import dtq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 445;

  class delta_list_board;
    logic [7:0]  task_slot[DEPTH];
    logic [15:0] delta_slot[DEPTH];
    int unsigned occupancy;
    logic [15:0] total_ticks;
    dtq_out_t    pending_reports[$];
    int unsigned mismatches;
    int unsigned reports_checked;
    int unsigned n_insert;
    int unsigned n_remove;
    int unsigned n_full;
    int unsigned n_empty;

    function new();
      occupancy       = 0;
      total_ticks     = '0;
      mismatches      = 0;
      reports_checked = 0;
      n_insert        = 0;
      n_remove        = 0;
      n_full          = 0;
      n_empty         = 0;
    endfunction

    // Shift entries at and behind pos back one slot, then drop the new entry in.
    function void place_entry(int unsigned pos, logic [7:0] id, logic [15:0] delta);
      for (int unsigned i = occupancy; i > pos; i--) begin
        task_slot[i]  = task_slot[i - 1];
        delta_slot[i] = delta_slot[i - 1];
      end
      task_slot[pos]  = id;
      delta_slot[pos] = delta;
      occupancy++;
    endfunction

    function logic [1:0] insert_task(logic [7:0] id, logic [15:0] delay);
      logic [15:0] rest;
      rest = delay;
      if (occupancy >= DEPTH) return STATUS_FULL;
      if (occupancy == 0) begin
        place_entry(0, id, rest);
        total_ticks = rest;
        return STATUS_DONE;
      end
      if (rest >= total_ticks) begin
        place_entry(occupancy, id, rest - total_ticks);
        total_ticks = rest;
        return STATUS_DONE;
      end
      for (int unsigned i = 0; i < occupancy; i++) begin
        if (delta_slot[i] >= rest) begin
          delta_slot[i] = delta_slot[i] - rest;
          place_entry(i, id, rest);
          return STATUS_DONE;
        end
        rest = rest - delta_slot[i];
      end
      // unreachable while the total matches the sum of the deltas
      place_entry(occupancy, id, rest);
      total_ticks = total_ticks + rest;
      return STATUS_DONE;
    endfunction

    function logic [1:0] remove_front();
      if (occupancy == 0) return STATUS_EMPTY;
      total_ticks = total_ticks - delta_slot[0];
      for (int unsigned i = 1; i < occupancy; i++) begin
        task_slot[i - 1]  = task_slot[i];
        delta_slot[i - 1] = delta_slot[i];
      end
      occupancy--;
      return STATUS_DONE;
    endfunction

    // Absolute expiry of the first k entries.
    function logic [15:0] prefix_ticks(int unsigned k);
      logic [15:0] sum;
      sum = '0;
      for (int unsigned i = 0; i < k && i < occupancy; i++) sum = sum + delta_slot[i];
      return sum;
    endfunction

    function void note_command(dtq_in_t w);
      dtq_out_t r;
      if (w.op == OP_INSERT) begin
        r.status = insert_task(w.task_id, w.delay_ticks);
        n_insert++;
      end else begin
        r.status = remove_front();
        n_remove++;
      end
      if (r.status == STATUS_FULL) n_full++;
      if (r.status == STATUS_EMPTY) n_empty++;
      r.front_task  = (occupancy > 0) ? task_slot[0] : 8'h00;
      r.front_delta = (occupancy > 0) ? delta_slot[0] : 16'h0000;
      r.entry_count = 5'(occupancy);
      pending_reports.push_back(r);
    endfunction

    function void check_report(dtq_out_t got);
      dtq_out_t want;
      if (pending_reports.size() == 0) begin
        $error("report word with none expected: %h", got);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.front_task !== want.front_task) begin
        $error("front_task: expected %0d, got %0d", want.front_task, got.front_task);
        mismatches++;
      end
      if (got.front_delta !== want.front_delta) begin
        $error("front_delta: expected %0d, got %0d", want.front_delta, got.front_delta);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  dtq_in_t  in_word_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  dtq_out_t out_word_o;

  delta_list_board board = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  bit filling = 1'b1;

  delta_timer_queue_top #(
    .QUEUE_DEPTH(DEPTH),
    .DELAY_BITS (16)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_report(out_word_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic dtq_in_t cmd(logic op, logic [7:0] id, logic [15:0] delay);
    dtq_in_t w;
    w.op          = op;
    w.task_id     = id;
    w.delay_ticks = delay;
    return w;
  endfunction

  // Hold the word until the block takes it, then log it with the model.
  task automatic send_command(dtq_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(w);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Favor delays that land exactly on or next to an existing expiry.
  function automatic logic [15:0] pick_delay();
    logic [15:0] base;
    base = board.prefix_ticks($urandom_range(board.occupancy));
    case ($urandom_range(5))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(65535));
      2: return 16'hFFFF;
      3: return base;
      4: return $urandom_range(1) ? base + 16'd1 : base - 16'd1;
      default: return board.total_ticks + 16'($urandom_range(3));
    endcase
  endfunction

  task automatic run_phase(int sender_idle, int receiver_stall, int n);
    dtq_in_t w;
    wait_for_drain();
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int k = 0; k < n; k++) begin
      if (board.occupancy == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (board.occupancy == 0 && $urandom_range(2) == 0) filling = 1'b1;
      if ($urandom_range(39) == 0) filling = !filling;
      if (($urandom_range(99) < 80) == filling) begin
        w = cmd(OP_INSERT, 8'($urandom_range(255)), pick_delay());
      end else begin
        w = cmd(OP_REMOVE, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end
      send_command(w);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(cmd(OP_REMOVE, 8'h00, 16'h0000));
    send_command(cmd(OP_INSERT, 8'h00, 16'h0000));
    send_command(cmd(OP_INSERT, 8'hFF, 16'hFFFF));
    send_command(cmd(OP_INSERT, 8'h01, 16'h0000));
    send_command(cmd(OP_INSERT, 8'h80, 16'h8000));
    send_command(cmd(OP_INSERT, 8'h7F, 16'h8000));
    send_command(cmd(OP_INSERT, 8'h55, 16'hFFFF));
    for (int k = 0; k < 10; k++) begin
      send_command(cmd(OP_INSERT, 8'h10 + 8'(k), 16'(60000 - 5900 * k)));
    end
    send_command(cmd(OP_INSERT, 8'h3C, 16'h1234));
    send_command(cmd(OP_REMOVE, 8'hFF, 16'hFFFF));
    send_command(cmd(OP_REMOVE, 8'h00, 16'h0000));
    send_command(cmd(OP_INSERT, 8'hC3, 16'h7FFF));
    send_command(cmd(OP_REMOVE, 8'hAA, 16'h5555));

    run_phase(0, 0, RAND_ITEMS);
    run_phase(49, 0, RAND_ITEMS);
    run_phase(0, 49, RAND_ITEMS);
    run_phase(26, 26, RAND_ITEMS);

    wait_for_drain();
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Covered %0d words: %0d inserts, %0d removes, %0d full rejects, %0d empty removes",
             board.n_insert + board.n_remove, board.n_insert, board.n_remove,
             board.n_full, board.n_empty);
    $display("Checked %0d reports across free-flowing, sender-gap, receiver-stall and mixed phases",
             board.reports_checked);
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
